### rtl/ilie_pkg.sv
// shared constants, codes and control/status types for the indexed list block
package ilie_pkg;

    // field widths of the item and result ports
    localparam int CMD_W   = 2;
    localparam int INDEX_W = 6;
    localparam int WORD_W  = 32;
    localparam int COUNT_W = 7;

    // default store depth
    localparam int DEPTH_DEF = 64;

    // command codes
    localparam logic [CMD_W-1:0] CMD_READ   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd1;
    localparam logic [CMD_W-1:0] CMD_ERASE  = 2'd2;

    // word returned by a bad read
    localparam logic [WORD_W-1:0] MIN_WORD = 32'h8000_0000;

    // memory read address selection
    localparam logic [1:0] RA_IDX  = 2'd0;
    localparam logic [1:0] RA_DOWN = 2'd1;
    localparam logic [1:0] RA_UP   = 2'd2;

    // commands from the controller to the datapath
    typedef struct packed {
        logic       take;
        logic       chk_load;
        logic       mem_rd;
        logic [1:0] rd_sel;
        logic       mem_wr;
        logic       wr_sel_val;
        logic       ptr_load_cnt;
        logic       ptr_load_idx;
        logic       ptr_inc;
        logic       ptr_dec;
        logic       cnt_inc;
        logic       cnt_dec;
        logic       out_load;
    } ctrl_cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic is_read;
        logic is_insert;
        logic is_erase;
        logic read_ok;
        logic insert_ok;
        logic erase_ok;
        logic insert_more;
        logic erase_more;
        logic out_free;
    } dp_status_t;

endpackage

### rtl/ilie_ctrl.sv
// controller state machine for the indexed list block
module ilie_ctrl
    import ilie_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  dp_status_t status,
    output ctrl_cmd_t  ctrl
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECODE = 3'd1;
    localparam logic [2:0] S_IMOVE  = 3'd2;
    localparam logic [2:0] S_IWR    = 3'd3;
    localparam logic [2:0] S_EMOVE  = 3'd4;
    localparam logic [2:0] S_EWR    = 3'd5;
    localparam logic [2:0] S_DONE   = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

    // next state and datapath commands
    always_comb
    begin
        state_next = state_reg;
        ctrl       = '0;
        ctrl.rd_sel = RA_IDX;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    ctrl.take  = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                // capture the verdict while the count is still the old one
                ctrl.chk_load = 1'b1;
                if (status.is_read && status.read_ok)
                begin
                    ctrl.mem_rd = 1'b1;
                    ctrl.rd_sel = RA_IDX;
                    state_next  = S_DONE;
                end
                else if (status.is_insert && status.insert_ok)
                begin
                    ctrl.ptr_load_cnt = 1'b1;
                    state_next        = S_IMOVE;
                end
                else if (status.is_erase && status.erase_ok)
                begin
                    ctrl.ptr_load_idx = 1'b1;
                    state_next        = S_EMOVE;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_IMOVE:
            begin
                if (status.insert_more)
                begin
                    ctrl.mem_rd = 1'b1;
                    ctrl.rd_sel = RA_DOWN;
                    state_next  = S_IWR;
                end
                else
                begin
                    ctrl.mem_wr     = 1'b1;
                    ctrl.wr_sel_val = 1'b1;
                    ctrl.cnt_inc    = 1'b1;
                    state_next      = S_DONE;
                end
            end
            S_IWR:
            begin
                ctrl.mem_wr  = 1'b1;
                ctrl.ptr_dec = 1'b1;
                state_next   = S_IMOVE;
            end
            S_EMOVE:
            begin
                if (status.erase_more)
                begin
                    ctrl.mem_rd = 1'b1;
                    ctrl.rd_sel = RA_UP;
                    state_next  = S_EWR;
                end
                else
                begin
                    ctrl.cnt_dec = 1'b1;
                    state_next   = S_DONE;
                end
            end
            S_EWR:
            begin
                ctrl.mem_wr  = 1'b1;
                ctrl.ptr_inc = 1'b1;
                state_next   = S_EMOVE;
            end
            S_DONE:
            begin
                if (status.out_free)
                begin
                    ctrl.out_load = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

### rtl/ilie_dpath.sv
// datapath: entry memory, count, move pointer and result register
module ilie_dpath
    import ilie_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  ctrl_cmd_t                 ctrl,
    output dp_status_t                status,
    input  logic [CMD_W-1:0]          cmd,
    input  logic [INDEX_W-1:0]        index,
    input  logic signed [WORD_W-1:0]  value,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic signed [WORD_W-1:0]  read_value,
    output logic                      error,
    output logic [COUNT_W-1:0]        count
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int XW = (CW > INDEX_W) ? CW : INDEX_W;
    localparam int EW = (XW > COUNT_W) ? XW : COUNT_W;

    logic [WORD_W-1:0]  mem [DEPTH];
    logic [WORD_W-1:0]  rdata_reg;
    logic [CMD_W-1:0]   cmd_reg;
    logic [INDEX_W-1:0] idx_reg;
    logic [WORD_W-1:0]  val_reg;
    logic               chk_err_reg;
    logic [CW-1:0]      cnt_reg;
    logic [AW-1:0]      ptr_reg;
    logic               out_valid_reg;
    logic [WORD_W-1:0]  read_value_reg;
    logic               error_reg;
    logic [CW-1:0]      count_reg;

    logic [XW-1:0]      idx_x;
    logic [XW-1:0]      cnt_x;
    logic [XW-1:0]      ptr_x;
    logic [EW-1:0]      count_e;
    logic [AW-1:0]      rd_addr;
    logic [WORD_W-1:0]  wr_data;
    logic               res_error;
    logic [WORD_W-1:0]  res_value;

    assign idx_x = XW'(idx_reg);
    assign cnt_x = XW'(cnt_reg);
    assign ptr_x = XW'(ptr_reg);

    // decode of the held item
    always_comb
    begin
        status.is_read     = (cmd_reg == CMD_READ);
        status.is_insert   = (cmd_reg == CMD_INSERT);
        status.is_erase    = (cmd_reg == CMD_ERASE);
        status.read_ok     = (idx_x < cnt_x);
        status.insert_ok   = (idx_x <= cnt_x) && (cnt_x < XW'(DEPTH));
        status.erase_ok    = (idx_x < cnt_x);
        status.insert_more = (ptr_x > idx_x);
        status.erase_more  = ((ptr_x + XW'(1)) < cnt_x);
        status.out_free    = !out_valid_reg || out_ready;
    end

    // memory address and write data selection
    always_comb
    begin
        case (ctrl.rd_sel)
            RA_DOWN: rd_addr = ptr_reg - AW'(1);
            RA_UP:   rd_addr = ptr_reg + AW'(1);
            default: rd_addr = idx_x[AW-1:0];
        endcase
        wr_data = ctrl.wr_sel_val ? val_reg : rdata_reg;
    end

    // entry memory, one write and one registered read
    always_ff @(posedge clk)
    begin
        if (ctrl.mem_wr)
        begin
            mem[ptr_reg] <= wr_data;
        end
        if (ctrl.mem_rd)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    // held item fields and the verdict taken against the old count
    always_ff @(posedge clk)
    begin
        if (ctrl.take)
        begin
            idx_reg <= index;
            val_reg <= value;
        end
        if (ctrl.chk_load)
        begin
            chk_err_reg <= res_error;
        end
    end

    // command register and move pointer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_reg <= CMD_READ;
            ptr_reg <= '0;
        end
        else
        begin
            if (ctrl.take)
            begin
                cmd_reg <= cmd;
            end
            if (ctrl.ptr_load_cnt)
            begin
                ptr_reg <= cnt_x[AW-1:0];
            end
            else if (ctrl.ptr_load_idx)
            begin
                ptr_reg <= idx_x[AW-1:0];
            end
            else if (ctrl.ptr_inc)
            begin
                ptr_reg <= ptr_reg + AW'(1);
            end
            else if (ctrl.ptr_dec)
            begin
                ptr_reg <= ptr_reg - AW'(1);
            end
        end
    end

    // entry count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (ctrl.cnt_inc)
        begin
            cnt_reg <= cnt_reg + CW'(1);
        end
        else if (ctrl.cnt_dec)
        begin
            cnt_reg <= cnt_reg - CW'(1);
        end
    end

    // result fields of the finished item
    always_comb
    begin
        res_error = 1'b0;
        res_value = '0;
        if (status.is_read)
        begin
            res_error = !status.read_ok;
            res_value = status.read_ok ? rdata_reg : MIN_WORD;
        end
        else if (status.is_insert)
        begin
            res_error = !status.insert_ok;
        end
        else if (status.is_erase)
        begin
            res_error = !status.erase_ok;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctrl.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.out_load)
        begin
            read_value_reg <= res_value;
            error_reg      <= chk_err_reg;
            count_reg      <= cnt_reg;
        end
    end

    assign count_e    = EW'(count_reg);
    assign out_valid  = out_valid_reg;
    assign read_value = read_value_reg;
    assign error      = error_reg;
    assign count      = count_e[COUNT_W-1:0];

endmodule

### rtl/indexed_list_insert_erase.sv
// top level of the indexed list with read, insert and erase at an index
//
// An ordered list of signed 32-bit words held in a memory of DEPTH entries.
// Input channel (in_valid/in_ready) carries cmd, index and value: cmd selects
// read, insert or erase at index; value is only used by insert.
// Output channel (out_valid/out_ready) carries one result per item:
// read_value (the word read, the most negative word on a bad read, else zero),
// error (index out of range or list full) and count (entries held after it).
// One item is handled at a time. A read or a rejected command goes from
// decode straight to the result state. An insert first moves the entries
// from index upward by one place and an erase moves those above index down
// by one, one entry per read/write state pair.
// The next item is accepted in the cycle after the result is loaded.
// The result sits in an output register, so the block returns to accept a
// new item while it waits; if the receiver stalls, the next item holds in
// its final cycle until the register frees.
// Reset clears the count to zero and empties the output register; the
// memory is not cleared, since only entries below the count are read.
module indexed_list_insert_erase
    import ilie_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [CMD_W-1:0]          cmd,
    input  logic [INDEX_W-1:0]        index,
    input  logic signed [WORD_W-1:0]  value,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic signed [WORD_W-1:0]  read_value,
    output logic                      error,
    output logic [COUNT_W-1:0]        count
);

    ctrl_cmd_t  ctrl;
    dp_status_t status;

    // sequencer
    ilie_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .ctrl     (ctrl)
    );

    // storage and result path
    ilie_dpath #(
        .DEPTH (DEPTH)
    ) u_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .status     (status),
        .cmd        (cmd),
        .index      (index),
        .value      (value),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .read_value (read_value),
        .error      (error),
        .count      (count)
    );

endmodule

### rtl/ilie_checker.sv
// port-level checks for the indexed list block, bound to the top level
module ilie_checker
    import ilie_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)
(
    input logic                      clk,
    input logic                      rst_n,
    input logic                      in_valid,
    input logic                      in_ready,
    input logic                      out_valid,
    input logic                      out_ready,
    input logic signed [WORD_W-1:0]  read_value,
    input logic                      error,
    input logic [COUNT_W-1:0]        count
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(read_value)
            && $stable(error) && $stable(count))
        else $error("result changed while stalled");

    // an accepted item keeps the input closed in the next cycle
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second item taken while one is in flight");

    // a rejected command carries either the bad-read marker or zero as its read word
    a_error_value: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && error |-> read_value == MIN_WORD || read_value == '0)
        else $error("error result with a data word");

    // the reported count never goes past the store depth (checked for depths up to 127)
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (DEPTH > 127) || (int'(count) <= DEPTH))
        else $error("count beyond depth");

endmodule

bind indexed_list_insert_erase ilie_checker #(.DEPTH(DEPTH)) u_ilie_checker (.*);
